// ----- rtl/mhpq_pkg.sv -----
// Shared types and constants for the max-heap priority queue.
// Holds the item structs, command and status codes, controller states and
// the control word sent from the controller to the level cells.
`timescale 1ns / 1ps
`default_nettype none

package mhpq_pkg;

  // default sizes
  localparam int CAPACITY_DEF   = 128;
  localparam int DATA_WIDTH_DEF = 32;

  // fixed field widths of the item ports
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 8;

  // control word widths, sized for the largest supported capacity
  localparam int HEAP_LVL_W = 4;
  localparam int HEAP_OFF_W = 12;

  typedef enum logic [1:0] {
    CMD_PUSH    = 2'd0,
    CMD_POP     = 2'd1,
    CMD_LOAD    = 2'd2,
    CMD_HEAPIFY = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_WAIT,
    S_HP_RD,
    S_HP_WAIT,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_e;

  typedef struct packed {
    cmd_e                      command;
    logic signed [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] popped_value;
    logic signed [VALUE_W-1:0] top_value;
    logic [COUNT_W-1:0]        entry_count;
    status_e                   status;
  } result_t;

  // one read and one write per cycle, each aimed at one tree level
  typedef struct packed {
    logic                  rd_en;
    logic [HEAP_LVL_W-1:0] rd_lvl;
    logic [HEAP_OFF_W-1:0] rd_off;
    logic                  wr_en;
    logic [HEAP_LVL_W-1:0] wr_lvl;
    logic [HEAP_OFF_W-1:0] wr_off;
  } mem_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/mhpq_cell.sv -----
// One tree level of the heap: the entries of that level in a local memory.
// Depends on mhpq_pkg. Read data returns up the chain toward level zero.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_cell import mhpq_pkg::*; #(
  parameter int LEVEL      = 0,
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire mem_ctrl_t             ctrl,
  input  wire logic [DATA_WIDTH-1:0] wr_data,
  input  wire logic [DATA_WIDTH-1:0] chain_a,
  input  wire logic [DATA_WIDTH-1:0] chain_b,
  output logic      [DATA_WIDTH-1:0] rd_a,
  output logic      [DATA_WIDTH-1:0] rd_b
);

  localparam int SPAN  = 1 << LEVEL;
  localparam int FIRST = SPAN - 1;
  localparam int DEPTH = (CAPACITY - FIRST < SPAN) ? (CAPACITY - FIRST) : SPAN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] a_q;
  logic [DATA_WIDTH-1:0] b_q;
  logic                  hit_q;
  logic                  rd_hit;
  logic                  wr_hit;
  logic [AW-1:0]         addr_a;
  logic [AW-1:0]         addr_b;

  // level decode; port b always reads the odd sibling
  assign rd_hit = ctrl.rd_en && (ctrl.rd_lvl == HEAP_LVL_W'(LEVEL));
  assign wr_hit = ctrl.wr_en && (ctrl.wr_lvl == HEAP_LVL_W'(LEVEL));
  assign addr_a = ctrl.rd_off[AW-1:0];
  assign addr_b = ctrl.rd_off[AW-1:0] | AW'(1);

  // write port
  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[ctrl.wr_off[AW-1:0]] <= wr_data;
    end
  end

  // registered read ports
  always_ff @(posedge clk) begin
    if (rd_hit) begin
      a_q <= mem[addr_a];
      b_q <= mem[addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= rd_hit;
    end
  end

  // put own data on the chain after a read, else pass the deeper level through
  assign rd_a = hit_q ? a_q : chain_a;
  assign rd_b = hit_q ? b_q : chain_b;

endmodule

`default_nettype wire

// ----- rtl/mhpq_ctrl.sv -----
// Command sequencer of the heap: sift-up, sift-down and heapify walks.
// Depends on mhpq_pkg. Drives the level cells and keeps count, tail and root.
`timescale 1ns / 1ps
`default_nettype none

module mhpq_ctrl import mhpq_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire request_t              request,
  output logic                       busy,
  output logic                       done,
  output result_t                    result,
  output mem_ctrl_t                  mem_ctrl,
  output logic      [DATA_WIDTH-1:0] mem_wdata,
  input  wire logic [DATA_WIDTH-1:0] rsp_a,
  input  wire logic [DATA_WIDTH-1:0] rsp_b
);

  localparam int NLEV = $clog2(CAPACITY + 1);
  localparam int LVW  = $clog2(NLEV + 1);
  localparam int OW   = (NLEV > 1) ? (NLEV - 1) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);

  // tree position as level and offset within the level
  typedef struct packed {
    logic [LVW-1:0] lvl;
    logic [OW-1:0]  off;
  } pos_t;

  function automatic pos_t pos_inc(input pos_t p);
    pos_t r;
    if (p.off == OW'((32'd1 << p.lvl) - 32'd1)) begin
      r.lvl = p.lvl + LVW'(1);
      r.off = '0;
    end else begin
      r.lvl = p.lvl;
      r.off = p.off + OW'(1);
    end
    return r;
  endfunction

  function automatic pos_t pos_dec(input pos_t p);
    pos_t r;
    if (p.off == '0) begin
      r.lvl = p.lvl - LVW'(1);
      r.off = OW'((32'd1 << r.lvl) - 32'd1);
    end else begin
      r.lvl = p.lvl;
      r.off = p.off - OW'(1);
    end
    return r;
  endfunction

  function automatic pos_t pos_parent(input pos_t p);
    pos_t r;
    r.lvl = p.lvl - LVW'(1);
    r.off = p.off >> 1;
    return r;
  endfunction

  state_e                state;
  state_e                state_next;
  logic [CW-1:0]         count;
  pos_t                  tail;
  pos_t                  node;
  pos_t                  pos;
  logic                  hflag;
  logic [DATA_WIDTH-1:0] carry;
  logic [DATA_WIDTH-1:0] root;
  logic [DATA_WIDTH-1:0] popped_r;
  status_e               status_r;

  logic                  accept;
  logic                  full;
  logic                  empty;
  logic [DATA_WIDTH-1:0] val_in;
  pos_t                  tail_inc;
  pos_t                  tail_dec;
  pos_t                  par_pos;
  pos_t                  child_pos;
  logic [LVW-1:0]        child_lvl;
  logic [OW:0]           left_off;
  logic [OW:0]           right_off;
  logic                  left_ok;
  logic                  right_ok;
  logic                  take_right;
  logic [DATA_WIDTH-1:0] big_val;
  logic                  dn_stop;
  logic                  up_stop;
  logic                  sift_more;
  state_e                end_state;

  // shared decisions
  assign accept   = start && (state == S_IDLE);
  assign full     = (count == CW'(CAPACITY));
  assign empty    = (count == '0);
  assign val_in   = DATA_WIDTH'($unsigned(request.value));
  assign tail_inc = pos_inc(tail);
  assign tail_dec = pos_dec(tail);
  assign par_pos  = pos_parent(pos);

  // children of pos exist when they come before the tail in level order
  assign child_lvl = pos.lvl + LVW'(1);
  assign left_off  = {pos.off, 1'b0};
  assign right_off = {pos.off, 1'b1};
  assign left_ok   = (child_lvl < tail.lvl) ||
                     ((child_lvl == tail.lvl) && (left_off < {1'b0, tail.off}));
  assign right_ok  = (child_lvl < tail.lvl) ||
                     ((child_lvl == tail.lvl) && (right_off < {1'b0, tail.off}));

  // sift-down compare: larger child, right only when strictly larger
  assign take_right    = right_ok && ($signed(rsp_b) > $signed(rsp_a));
  assign big_val       = take_right ? rsp_b : rsp_a;
  assign dn_stop       = $signed(carry) > $signed(big_val);
  assign child_pos.lvl = child_lvl;
  assign child_pos.off = take_right ? OW'(right_off) : OW'(left_off);

  // sift-up compare against the parent
  assign up_stop = $signed(rsp_a) >= $signed(carry);

  // heapify goes on with the previous node until the root is done
  assign sift_more = hflag && (node.lvl != '0);
  assign end_state = sift_more ? S_HP_RD : S_DONE;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (request.command)
            CMD_PUSH:    state_next = full ? S_DONE : S_UP_RD;
            CMD_LOAD:    state_next = S_DONE;
            CMD_POP:     state_next = (empty || count == CW'(1)) ? S_DONE : S_POP_RD;
            CMD_HEAPIFY: state_next = (count < CW'(2)) ? S_DONE : S_HP_RD;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_UP_RD:    state_next = (pos.lvl == '0) ? S_DONE : S_UP_CMP;
      S_UP_CMP:   state_next = up_stop ? S_DONE : S_UP_RD;
      S_POP_RD:   state_next = S_POP_WAIT;
      S_POP_WAIT: state_next = S_DN_RD;
      S_HP_RD:    state_next = S_HP_WAIT;
      S_HP_WAIT:  state_next = S_DN_RD;
      S_DN_RD:    state_next = left_ok ? S_DN_CMP : end_state;
      S_DN_CMP:   state_next = dn_stop ? end_state : S_DN_RD;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // memory control and handshake outputs
  always_comb begin
    mem_ctrl  = '0;
    mem_wdata = carry;
    case (state)
      S_IDLE: begin
        if (accept && request.command == CMD_LOAD && !full) begin
          mem_ctrl.wr_en  = 1'b1;
          mem_ctrl.wr_lvl = HEAP_LVL_W'(tail.lvl);
          mem_ctrl.wr_off = HEAP_OFF_W'(tail.off);
          mem_wdata       = val_in;
        end
      end
      S_UP_RD: begin
        if (pos.lvl == '0) begin
          mem_ctrl.wr_en  = 1'b1;
          mem_ctrl.wr_lvl = HEAP_LVL_W'(pos.lvl);
          mem_ctrl.wr_off = HEAP_OFF_W'(pos.off);
        end else begin
          mem_ctrl.rd_en  = 1'b1;
          mem_ctrl.rd_lvl = HEAP_LVL_W'(par_pos.lvl);
          mem_ctrl.rd_off = HEAP_OFF_W'(par_pos.off);
        end
      end
      S_UP_CMP: begin
        mem_ctrl.wr_en  = 1'b1;
        mem_ctrl.wr_lvl = HEAP_LVL_W'(pos.lvl);
        mem_ctrl.wr_off = HEAP_OFF_W'(pos.off);
        mem_wdata       = up_stop ? carry : rsp_a;
      end
      S_POP_RD: begin
        mem_ctrl.rd_en  = 1'b1;
        mem_ctrl.rd_lvl = HEAP_LVL_W'(tail.lvl);
        mem_ctrl.rd_off = HEAP_OFF_W'(tail.off);
      end
      S_HP_RD: begin
        mem_ctrl.rd_en  = 1'b1;
        mem_ctrl.rd_lvl = HEAP_LVL_W'(node.lvl);
        mem_ctrl.rd_off = HEAP_OFF_W'(node.off);
      end
      S_DN_RD: begin
        if (left_ok) begin
          mem_ctrl.rd_en  = 1'b1;
          mem_ctrl.rd_lvl = HEAP_LVL_W'(child_lvl);
          mem_ctrl.rd_off = HEAP_OFF_W'(OW'(left_off));
        end else begin
          mem_ctrl.wr_en  = 1'b1;
          mem_ctrl.wr_lvl = HEAP_LVL_W'(pos.lvl);
          mem_ctrl.wr_off = HEAP_OFF_W'(pos.off);
        end
      end
      S_DN_CMP: begin
        mem_ctrl.wr_en  = 1'b1;
        mem_ctrl.wr_lvl = HEAP_LVL_W'(pos.lvl);
        mem_ctrl.wr_off = HEAP_OFF_W'(pos.off);
        mem_wdata       = dn_stop ? carry : big_val;
      end
      default: begin
        mem_ctrl = '0;
      end
    endcase
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      tail  <= '0;
      hflag <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        case (request.command)
          CMD_PUSH, CMD_LOAD: begin
            hflag <= 1'b0;
            if (!full) begin
              count <= count + CW'(1);
              tail  <= tail_inc;
            end
          end
          CMD_POP: begin
            hflag <= 1'b0;
            if (!empty) begin
              count <= count - CW'(1);
              tail  <= tail_dec;
            end
          end
          CMD_HEAPIFY: begin
            hflag <= (count >= CW'(2));
          end
          default: begin
            hflag <= 1'b0;
          end
        endcase
      end
    end
  end

  // walk registers and result payload
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          carry <= val_in;
          pos   <= tail;
          case (request.command)
            CMD_PUSH, CMD_LOAD: begin
              popped_r <= '0;
              status_r <= full ? ST_FULL : ST_OK;
            end
            CMD_POP: begin
              popped_r <= empty ? '0 : root;
              status_r <= empty ? ST_EMPTY : ST_OK;
            end
            CMD_HEAPIFY: begin
              popped_r <= '0;
              status_r <= ST_OK;
              node     <= pos_parent(tail_dec);
            end
            default: begin
              popped_r <= '0;
              status_r <= ST_OK;
            end
          endcase
        end
      end
      S_UP_CMP: begin
        if (!up_stop) begin
          pos <= par_pos;
        end
      end
      S_POP_WAIT: begin
        carry <= rsp_a;
        pos   <= '0;
      end
      S_HP_WAIT: begin
        carry <= rsp_a;
        pos   <= node;
      end
      S_DN_RD: begin
        if (!left_ok && sift_more) begin
          node <= pos_dec(node);
        end
      end
      S_DN_CMP: begin
        if (!dn_stop) begin
          pos <= child_pos;
        end else if (sift_more) begin
          node <= pos_dec(node);
        end
      end
      default: begin
        carry <= carry;
      end
    endcase
  end

  // mirror of the root entry for pop and the top output
  always_ff @(posedge clk) begin
    if (mem_ctrl.wr_en && mem_ctrl.wr_lvl == '0) begin
      root <= mem_wdata;
    end
  end

  // result item
  always_comb begin
    result.popped_value = VALUE_W'(popped_r);
    result.top_value    = empty ? '0 : VALUE_W'(root);
    result.entry_count  = COUNT_W'(count);
    result.status       = status_r;
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_then_idle: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy)
    else $error("still busy after result strobe");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && status_r == ST_FULL) |-> full)
    else $error("full status without full heap");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && status_r == ST_EMPTY) |-> (empty && popped_r == '0))
    else $error("empty status with entries or popped data");

  a_no_level_clash: assert property (@(posedge clk) disable iff (rst)
    !(mem_ctrl.rd_en && mem_ctrl.wr_en && mem_ctrl.rd_lvl == mem_ctrl.wr_lvl))
    else $error("read and write on one level in one cycle");

endmodule

`default_nettype wire

// ----- rtl/max_heap_priority_queue.sv -----
// Top level of the max-heap priority queue: sequencer plus a chain of level cells.
// Depends on mhpq_pkg, mhpq_ctrl and mhpq_cell.
`timescale 1ns / 1ps
`default_nettype none

// Binary max-heap of signed words, one memory cell per tree level. An item is
// taken when start is high and busy is low; busy stays high until the result
// cycle ends, and the result is shown for exactly one cycle with done high.
// The receiver cannot stall, so it must take the result in that cycle.
// Each tree level walked takes a registered read of the level cell and then
// a compare-and-write. Push and pop compare at most one entry per level below
// the root, up to 7 levels for 128 entries; load and every refused command go
// straight from idle to the result cycle; heapify sifts down every internal
// node in turn, from the parent of the last entry back to the root. The heap
// memory needs no clearing after reset: entries above the count are never used.
module max_heap_priority_queue import mhpq_pkg::*; #(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  input  wire request_t request,
  output logic          busy,
  output logic          done,
  output result_t       result
);

  localparam int NLEV = $clog2(CAPACITY + 1);

  mem_ctrl_t             mem_ctrl;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic [DATA_WIDTH-1:0] chain_a [NLEV+1];
  logic [DATA_WIDTH-1:0] chain_b [NLEV+1];

  // sequencer
  mhpq_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .mem_ctrl  (mem_ctrl),
    .mem_wdata (mem_wdata),
    .rsp_a     (chain_a[0]),
    .rsp_b     (chain_b[0])
  );

  // end of the read-return chain
  assign chain_a[NLEV] = '0;
  assign chain_b[NLEV] = '0;

  // one cell per tree level
  for (genvar g = 0; g < NLEV; g++) begin : g_level
    mhpq_cell #(
      .LEVEL      (g),
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (mem_ctrl),
      .wr_data (mem_wdata),
      .chain_a (chain_a[g+1]),
      .chain_b (chain_b[g+1]),
      .rd_a    (chain_a[g]),
      .rd_b    (chain_b[g])
    );
  end

endmodule

`default_nettype wire
